FILE: design/upc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package upc_pkg;

  localparam int QUEUE_DEPTH = 2;

  // Mode codes.
  localparam logic [2:0] MODE_DEC_QUERY = 3'd0;
  localparam logic [2:0] MODE_DEC_USER  = 3'd1;
  localparam logic [2:0] MODE_DEC_PATH  = 3'd2;
  localparam logic [2:0] MODE_DEC_FRAG  = 3'd3;
  localparam logic [2:0] MODE_ENC_QUERY = 3'd4;
  localparam logic [2:0] MODE_ENC_USER  = 3'd5;
  localparam logic [2:0] MODE_ENC_PATH  = 3'd6;
  localparam logic [2:0] MODE_ENC_FRAG  = 3'd7;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic       esc;
    logic [7:0] data;
    logic       send;
    logic       err;
  } upc_job_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h2d, 8'h2e, 8'h5f: r = 1'b1;
      default:             r = 1'b0;
    endcase
    return is_alnum(c) || r;
  endfunction

  function automatic logic is_basic(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c,
      8'h3b, 8'h3d:        r = 1'b1;
      default:             r = 1'b0;
    endcase
    return is_unreserved(c) || r;
  endfunction

  function automatic logic is_frag(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h3a, 8'h40, 8'h2f, 8'h3f: r = 1'b1;
      default:                    r = 1'b0;
    endcase
    return is_basic(c) || r;
  endfunction

  function automatic logic enc_allowed(input logic [2:0] mode, input logic [7:0] c);
    logic r;
    case (mode)
      MODE_ENC_QUERY: r = is_unreserved(c);
      MODE_ENC_USER:  r = is_basic(c);
      MODE_ENC_PATH:  r = is_basic(c) || (c == 8'h2f);
      default:        r = is_frag(c);
    endcase
    return r;
  endfunction

  // Returns {valid, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h57 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/url_percent_codec.sv
// A byte's job passes the job queue, then the output stage, which offers its first word.
// Throughput: one byte per cycle when each byte yields at most one word and the output does
// not stall; a percent-encoded byte holds the single output port for its three words, and
// the job queue between classifier and word generator absorbs short stalls on either side.
// Reset (synchronous, active high) closes any open escape, ends discarding and empties
// the queue and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_codec #(
  parameter int QUEUE_DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] mode,
  input  wire logic [7:0] byte_in,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      byte_out,
  output logic            run_end,
  output logic            string_end,
  output logic            error
);
  import upc_pkg::*;

  upc_job_t push_job, head;
  logic     push, pop, space_ok, nonempty;

  upc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .byte_in  (byte_in),
    .last     (last),
    .space_ok (space_ok),
    .push     (push),
    .job      (push_job)
  );

  upc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .space_ok (space_ok),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  upc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_avail  (nonempty),
    .job_in     (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_out   (byte_out),
    .run_end    (run_end),
    .string_end (string_end),
    .error      (error)
  );

endmodule

`default_nettype wire

FILE: design/upc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module upc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         mode,
  input  wire logic [7:0]         byte_in,
  input  wire logic               last,
  input  wire logic               space_ok,
  output logic                    push,
  output upc_pkg::upc_job_t       job
);
  import upc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  logic [1:0] phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       discarding, discarding_next;
  logic       res_valid;
  logic [4:0] hv;
  logic       accept;

  assign in_ready = space_ok;
  assign accept   = in_valid && in_ready;
  assign push     = accept && res_valid;
  assign hv       = hex_value(byte_in);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    discarding_next  = discarding;
    res_valid        = 1'b0;
    job              = '0;
    job.data         = byte_in;
    job.send         = last;

    if (discarding) begin
      if (last) begin
        discarding_next  = 1'b0;
        phase_next       = PH_IDLE;
        high_nibble_next = 4'h0;
      end
    end else if (phase == PH_HIGH) begin
      if (!hv[4] || last) begin
        res_valid = 1'b1;
      end else begin
        high_nibble_next = hv[3:0];
        phase_next       = PH_LOW;
      end
    end else if (phase == PH_LOW) begin
      res_valid = 1'b1;
      if (hv[4]) begin
        job.data         = {high_nibble, hv[3:0]};
        phase_next       = PH_IDLE;
        high_nibble_next = 4'h0;
      end
    end else if (!mode[2]) begin
      if (byte_in == CH_PERCENT) begin
        if (last) begin
          res_valid = 1'b1;
        end else begin
          phase_next = PH_HIGH;
        end
      end else begin
        res_valid = 1'b1;
        if (mode == MODE_DEC_QUERY && byte_in == CH_PLUS) begin
          job.data = CH_SPACE;
        end
      end
    end else begin
      res_valid = 1'b1;
      job.esc   = !enc_allowed(mode, byte_in);
    end

    // Error cases all produce the same single error word and reset the escape.
    if (!discarding && res_valid &&
        ((phase == PH_HIGH) || (phase == PH_LOW && !hv[4]) ||
         (phase == PH_IDLE && !mode[2] &&
          ((byte_in == CH_PERCENT) ||
           (mode == MODE_DEC_USER && !is_basic(byte_in)) ||
           (mode == MODE_DEC_FRAG && !is_frag(byte_in)))))) begin
      job.esc          = 1'b0;
      job.data         = 8'h00;
      job.send         = 1'b1;
      job.err          = 1'b1;
      phase_next       = PH_IDLE;
      high_nibble_next = 4'h0;
      discarding_next  = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= 4'h0;
      discarding  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      discarding  <= discarding_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/upc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module upc_queue #(
  parameter int DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire upc_pkg::upc_job_t  push_job,
  output logic                    space_ok,
  input  wire logic               pop,
  output logic                    nonempty,
  output upc_pkg::upc_job_t       head
);
  import upc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  upc_job_t         entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign space_ok = (count != CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/upc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module upc_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_avail,
  input  wire upc_pkg::upc_job_t  job_in,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              byte_out,
  output logic                    run_end,
  output logic                    string_end,
  output logic                    error
);
  import upc_pkg::*;

  localparam logic [1:0] STEP_PCT = 2'd0;
  localparam logic [1:0] STEP_HI  = 2'd1;
  localparam logic [1:0] STEP_LO  = 2'd2;

  upc_job_t   cur;
  logic [1:0] step;
  logic       final_word;

  assign final_word = !cur.esc || (step == STEP_LO);
  assign pop        = job_avail && (!out_valid || (out_ready && final_word));

  always_comb begin
    byte_out   = cur.data;
    run_end    = 1'b1;
    string_end = cur.send;
    error      = cur.err;
    if (cur.esc) begin
      unique case (step)
        STEP_PCT: begin
          byte_out   = CH_PERCENT;
          run_end    = 1'b0;
          string_end = 1'b0;
        end
        STEP_HI: begin
          byte_out   = hex_lower(cur.data[7:4]);
          run_end    = 1'b0;
          string_end = 1'b0;
        end
        default: byte_out = hex_lower(cur.data[3:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= STEP_PCT;
    end else if (pop) begin
      out_valid <= 1'b1;
      step      <= STEP_PCT;
    end else if (out_valid && out_ready) begin
      if (final_word) begin
        out_valid <= 1'b0;
        step      <= STEP_PCT;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/upc_checker.sv
`timescale 1ns / 1ps

module upc_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [2:0] mode,
  input  wire logic [7:0] byte_in,
  input  wire logic       last,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] byte_out,
  input  wire logic       run_end,
  input  wire logic       string_end,
  input  wire logic       error,
  output int              words_pending,
  output int              fail_count
);

  import upc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_done;
    logic       str_done;
    logic       err;
  } codec_word_t;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_HIGH,
    ESC_LOW
  } esc_phase_t;

  codec_word_t expected_words[$];
  esc_phase_t  esc_phase = ESC_NONE;
  logic [3:0]  esc_high = 4'h0;
  logic        dropping = 1'b0;
  int          fails = 0;
  int          pending = 0;

  assign fail_count    = fails;
  assign words_pending = pending;

  function automatic logic ch_alnum(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic logic ch_unreserved(input logic [7:0] c);
    return ch_alnum(c) || c == "-" || c == "." || c == "_";
  endfunction

  function automatic logic ch_host(input logic [7:0] c);
    logic r;
    case (c)
      "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r || ch_unreserved(c);
  endfunction

  function automatic logic ch_frag(input logic [7:0] c);
    return ch_host(c) || c == ":" || c == "@" || c == "/" || c == "?";
  endfunction

  function automatic logic enc_keeps(input logic [2:0] m, input logic [7:0] c);
    logic r;
    case (m)
      MODE_ENC_QUERY: r = ch_unreserved(c);
      MODE_ENC_USER:  r = ch_host(c);
      MODE_ENC_PATH:  r = ch_host(c) || c == "/";
      default:        r = ch_frag(c);
    endcase
    return r;
  endfunction

  // Top bit says whether the byte is a hex digit at all.
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    ok = 1'b1;
    d  = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end else begin
      ok = 1'b0;
    end
    return {ok, d[3:0]};
  endfunction

  function automatic logic [7:0] lower_hex_char(input logic [3:0] n);
    return (n < 4'd10) ? "0" + {4'h0, n} : "a" + {4'h0, n} - 8'd10;
  endfunction

  task automatic push_word(input logic [7:0] d, input logic re, input logic se,
                           input logic er);
    expected_words.push_back({d, re, se, er});
  endtask

  // A decode error gives one word and drops the rest of the string unless it ended here.
  task automatic push_error(input logic l);
    esc_phase = ESC_NONE;
    esc_high  = 4'h0;
    dropping  = !l;
    push_word(8'h00, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic predict_codec_words(input logic [2:0] m, input logic [7:0] b,
                                     input logic l);
    logic [4:0] hv;
    hv = hex_digit_value(b);
    if (dropping) begin
      if (l) begin
        dropping  = 1'b0;
        esc_phase = ESC_NONE;
        esc_high  = 4'h0;
      end
    end else if (esc_phase == ESC_HIGH) begin
      if (!hv[4] || l) begin
        push_error(l);
      end else begin
        esc_high  = hv[3:0];
        esc_phase = ESC_LOW;
      end
    end else if (esc_phase == ESC_LOW) begin
      if (!hv[4]) begin
        push_error(l);
      end else begin
        push_word({esc_high, hv[3:0]}, 1'b1, l, 1'b0);
        esc_phase = ESC_NONE;
        esc_high  = 4'h0;
      end
    end else if (m < MODE_ENC_QUERY) begin
      if (b == CH_PERCENT) begin
        if (l) begin
          push_error(l);
        end else begin
          esc_phase = ESC_HIGH;
        end
      end else if (m == MODE_DEC_QUERY && b == CH_PLUS) begin
        push_word(CH_SPACE, 1'b1, l, 1'b0);
      end else if ((m == MODE_DEC_USER && !ch_host(b)) ||
                   (m == MODE_DEC_FRAG && !ch_frag(b))) begin
        push_error(l);
      end else begin
        push_word(b, 1'b1, l, 1'b0);
      end
    end else if (enc_keeps(m, b)) begin
      push_word(b, 1'b1, l, 1'b0);
    end else begin
      push_word(CH_PERCENT, 1'b0, 1'b0, 1'b0);
      push_word(lower_hex_char(b[7:4]), 1'b0, 1'b0, 1'b0);
      push_word(lower_hex_char(b[3:0]), 1'b1, l, 1'b0);
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    codec_word_t want;
    if (rst) begin
      expected_words.delete();
      esc_phase = ESC_NONE;
      esc_high  = 4'h0;
      dropping  = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: word not expected, expected none, got %h run_end=%b string_end=%b error=%b",
                   $time, byte_out, run_end, string_end, error);
        end else begin
          want = expected_words.pop_front();
          compare_field("byte_out", want.data, byte_out);
          compare_field("run_end", {7'h0, want.run_done}, {7'h0, run_end});
          compare_field("string_end", {7'h0, want.str_done}, {7'h0, string_end});
          compare_field("error", {7'h0, want.err}, {7'h0, error});
        end
      end
      if (in_valid && in_ready) begin
        predict_codec_words(mode, byte_in, last);
      end
    end
    pending = expected_words.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  import upc_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 230;
  localparam int CALM_TAIL    = 50;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] mode = 3'h0;
  logic [7:0] byte_in = 8'h00;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_out;
  logic       run_end;
  logic       string_end;
  logic       error;

  int         words_pending;
  int         fail_count;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  int         random_bytes = 0;
  bit         idle_on = 1'b1;

  logic [2:0] str_mode[$];
  logic [7:0] str_byte[$];

  string      plain_chars = "aZ09-._~!$&'()*+,;=:@/?mQ5 ";
  string      hex_chars   = "0123456789abcdefABCDEF";

  url_percent_codec u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .byte_in    (byte_in),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_out   (byte_out),
    .run_end    (run_end),
    .string_end (string_end),
    .error      (error)
  );

  upc_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .byte_in       (byte_in),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_out      (byte_out),
    .run_end       (run_end),
    .string_end    (string_end),
    .error         (error),
    .words_pending (words_pending),
    .fail_count    (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side stalls in bursts while idling is enabled.
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [2:0] m, input logic [7:0] b, input logic l);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    byte_in  <= b;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Most bytes keep the string's mode; a few get a random one.
  task automatic add_byte(input logic [2:0] m, input logic [7:0] c);
    if ($urandom_range(0, 9) == 0) begin
      str_mode.push_back(3'($urandom_range(0, 7)));
    end else begin
      str_mode.push_back(m);
    end
    str_byte.push_back(c);
  endtask

  task automatic make_random_string();
    logic [2:0] m;
    int         len;
    int         kind;
    m   = 3'($urandom_range(0, 7));
    len = $urandom_range(1, 10);
    str_mode.delete();
    str_byte.delete();
    while (str_byte.size() < len) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        add_byte(m, plain_chars[$urandom_range(0, plain_chars.len() - 1)]);
      end else if (kind < 8 && m < MODE_ENC_QUERY) begin
        add_byte(m, CH_PERCENT);
        add_byte(m, hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        add_byte(m, hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
      end else if (kind == 8) begin
        add_byte(m, CH_PLUS);
      end else begin
        add_byte(m, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Byte extremes through the pass-through decoder.
    send_byte(MODE_DEC_PATH, 8'h00, 1'b0);
    send_byte(MODE_DEC_PATH, 8'hff, 1'b1);
    // Plus to space, then an upper-case escape.
    send_byte(MODE_DEC_QUERY, CH_PLUS, 1'b0);
    send_byte(MODE_DEC_QUERY, CH_PERCENT, 1'b0);
    send_byte(MODE_DEC_QUERY, "4", 1'b0);
    send_byte(MODE_DEC_QUERY, "A", 1'b0);
    // Lower-case escape whose digits carry an encode mode; the open escape wins.
    send_byte(MODE_DEC_QUERY, CH_PERCENT, 1'b0);
    send_byte(MODE_ENC_PATH, "6", 1'b0);
    send_byte(MODE_ENC_FRAG, "f", 1'b1);
    // Invalid userinfo character, then the rest of the string is dropped.
    send_byte(MODE_DEC_USER, " ", 1'b0);
    send_byte(MODE_DEC_USER, "x", 1'b0);
    send_byte(MODE_DEC_USER, CH_PERCENT, 1'b1);
    // Invalid fragment character on the final byte.
    send_byte(MODE_DEC_FRAG, "#", 1'b1);
    // Escape cut short right after the percent sign, then after one digit.
    send_byte(MODE_DEC_PATH, CH_PERCENT, 1'b1);
    send_byte(MODE_DEC_PATH, CH_PERCENT, 1'b0);
    send_byte(MODE_DEC_PATH, "4", 1'b1);
    // Bad high digit, then a dropped tail.
    send_byte(MODE_DEC_QUERY, CH_PERCENT, 1'b0);
    send_byte(MODE_DEC_QUERY, "g", 1'b0);
    send_byte(MODE_DEC_QUERY, "a", 1'b1);
    // Bad low digit on the final byte.
    send_byte(MODE_DEC_FRAG, CH_PERCENT, 1'b0);
    send_byte(MODE_DEC_FRAG, "4", 1'b0);
    send_byte(MODE_DEC_FRAG, "z", 1'b1);
    // One byte per encode mode, then a second fragment byte.
    send_byte(MODE_ENC_QUERY, "~", 1'b0);
    send_byte(MODE_ENC_USER, CH_PLUS, 1'b0);
    send_byte(MODE_ENC_PATH, "/", 1'b0);
    send_byte(MODE_ENC_FRAG, "?", 1'b0);
    send_byte(MODE_ENC_FRAG, 8'hff, 1'b1);

    while (random_bytes < RANDOM_ITEMS) begin
      make_random_string();
      foreach (str_byte[i]) begin
        idle_on = (random_bytes < RANDOM_ITEMS - CALM_TAIL);
        send_byte(str_mode[i], str_byte[i], i == str_byte.size() - 1);
        random_bytes++;
      end
    end
    idle_on = 1'b0;
    in_valid <= 1'b0;

    while (words_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/upc_pkg.sv
design/upc_front.sv
design/upc_queue.sv
design/upc_back.sv
design/url_percent_codec.sv
dv/upc_checker.sv
dv/tb.sv
